// ----- rtl/dws_pkg.sv -----
// Shared types, constants and elaboration-time functions for the damped
// wave stencil cell. Used by every module of the block; depends on nothing.
package dws_pkg;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 24;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_COURANT_A = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COURANT_B = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DAMP_A    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DAMP_B    = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STIFF_A   = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STIFF_B   = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DAMP_SIDE = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_STIFF_SIDE = 8'd7;

  // Reset values of the coefficient registers.
  localparam logic [15:0] RST_COURANT_A  = 16'd1311;
  localparam logic [15:0] RST_COURANT_B  = 16'd655;
  localparam logic [23:0] RST_DAMP_A     = 24'd34;
  localparam logic [23:0] RST_DAMP_B     = 24'd4194;
  localparam logic [23:0] RST_STIFF_A    = 24'd0;
  localparam logic [23:0] RST_STIFF_B    = 24'd17;
  localparam logic [23:0] RST_DAMP_SIDE  = 24'd1678;
  localparam logic [23:0] RST_STIFF_SIDE = 24'd8389;

  // Fixed coefficients of the top and bottom absorbing edges.
  localparam logic [23:0] TOPBOT_DAMP  = 24'd17;
  localparam logic [23:0] TOPBOT_STIFF = 24'd0;

  // Saturation limit, 10.0 in Q5.18.
  localparam logic signed [63:0] VMAX_Q = 64'sd2621440;

  // Half-LSB biases for round half up after the final shift.
  localparam logic signed [63:0] RND_INTERIOR = 64'sd2147483648;
  localparam logic signed [63:0] RND_EDGE     = 64'sd8388608;

  localparam logic [63:0] ONE_Q30     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [1:0] {
    KIND_INTERIOR = 2'd0,
    KIND_TOPBOT   = 2'd1,
    KIND_SIDE     = 2'd2,
    KIND_DRIVEN   = 2'd3
  } edge_kind_t;

  typedef struct packed {
    logic [15:0] courant_a;
    logic [15:0] courant_b;
    logic [23:0] damp_a;
    logic [23:0] damp_b;
    logic [23:0] stiff_a;
    logic [23:0] stiff_b;
    logic [23:0] damp_side;
    logic [23:0] stiff_side;
  } coef_t;

  // Clamp a wide signed value to plus or minus 10.0 in Q5.18.
  function automatic logic signed [22:0] sat10(input logic signed [63:0] v);
    logic signed [22:0] r;
    if (v > VMAX_Q) begin
      r = 23'(VMAX_Q);
    end else if (v < -VMAX_Q) begin
      r = 23'(-VMAX_Q);
    end else begin
      r = 23'(v);
    end
    return r;
  endfunction

  // Sine of an angle in Q32 turns, Q5.18 result. Quadrant folding and an
  // odd Taylor series of degree 11 in Q30. Only evaluated at elaboration.
  function automatic logic signed [22:0] sine_from_angle(input logic [63:0] ang);
    logic [1:0]  q;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    logic signed [22:0] res;
    q  = ang[31:30];
    r  = {34'd0, ang[29:0]};
    if (q[0]) begin
      r = ONE_Q30 - r;
    end
    x  = (r * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    v  = (s + 64'd2048) >> 12;
    res = 23'(v);
    if (q[1]) begin
      res = -res;
    end
    return res;
  endfunction

endpackage

// ----- rtl/damped_wave_stencil_cell.sv -----
// Top level of the damped wave stencil cell: coefficient registers and the
// update pipeline. Depends on dws_pkg, dws_cfg_regs, dws_pipe, dws_sine_rom.

// The block updates one grid cell of a damped two-medium wave equation per
// word and accepts a new word every clock cycle while results are taken. A
// word moves through four register stages (operand preparation with the
// Courant square, the three field products with the sine ROM read, aligned
// partial sums, and the final sum with its rounding shift and saturation).
// The first stage loads at the edge that takes the word, and the last stage
// is the output register.
// Each stage holds its word while the one after it is full, so a stall on the
// output side backs up stage by stage and in_ready falls only when every
// stage is occupied; results come out in order, one per input word. Interior
// cells use the five-point Laplacian times Courant squared, less stiffness
// and damping terms; top and bottom edges use a one-sided absorbing rule with
// fixed light damping; left and right edges use the same rule with their own
// registers; driven cells take a sine sample, with negative phases clamped to
// zero and the phase wrapping each turn. Both outputs saturate at plus or
// minus 10.0 in Q5.18. The sine table has SINE_TABLE_DEPTH entries and is
// built at elaboration. Coefficient registers are written through the cfg
// channel, which is always ready; writes must happen while no word is in
// flight, and an index outside the eight registers is ignored.
module damped_wave_stencil_cell #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  // Coefficient write channel.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dws_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dws_pkg::CFG_DATA_W-1:0]    cfg_data,
  // Cell input channel.
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [23:0]                phi_center,
  input  logic signed [23:0]                phi_east,
  input  logic signed [23:0]                phi_west,
  input  logic signed [23:0]                phi_north,
  input  logic signed [23:0]                phi_south,
  input  logic signed [23:0]                phi_inward,
  input  logic signed [23:0]                psi_center,
  input  logic                              in_medium_a,
  input  logic [1:0]                        edge_kind,
  input  logic signed [31:0]                drive_phase,
  // Result channel.
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [22:0]                phi_next,
  output logic signed [22:0]                psi_next
);

  // Current coefficient set, read by the first pipeline stage.
  dws_pkg::coef_t coef;

  dws_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef)
  );

  // The pipeline reads the coefficients in its first stage only, which is
  // why writes while words are in flight are not supported.
  dws_pipe #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_pipe (
    .clk         (clk),
    .rst         (rst),
    .coef        (coef),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .phi_center  (phi_center),
    .phi_east    (phi_east),
    .phi_west    (phi_west),
    .phi_north   (phi_north),
    .phi_south   (phi_south),
    .phi_inward  (phi_inward),
    .psi_center  (psi_center),
    .in_medium_a (in_medium_a),
    .edge_kind   (edge_kind),
    .drive_phase (drive_phase),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .phi_next    (phi_next),
    .psi_next    (psi_next)
  );

endmodule

// ----- rtl/dws_cfg_regs.sv -----
// Coefficient register file of the damped wave stencil cell.
// Depends on dws_pkg for register indexes, reset values and coef_t.
module dws_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dws_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dws_pkg::CFG_DATA_W-1:0]    cfg_data,
  output dws_pkg::coef_t                    coef
);

  // Writes are always taken; an index outside the list is dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef.courant_a  <= dws_pkg::RST_COURANT_A;
      coef.courant_b  <= dws_pkg::RST_COURANT_B;
      coef.damp_a     <= dws_pkg::RST_DAMP_A;
      coef.damp_b     <= dws_pkg::RST_DAMP_B;
      coef.stiff_a    <= dws_pkg::RST_STIFF_A;
      coef.stiff_b    <= dws_pkg::RST_STIFF_B;
      coef.damp_side  <= dws_pkg::RST_DAMP_SIDE;
      coef.stiff_side <= dws_pkg::RST_STIFF_SIDE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        dws_pkg::REG_COURANT_A:  coef.courant_a  <= cfg_data[15:0];
        dws_pkg::REG_COURANT_B:  coef.courant_b  <= cfg_data[15:0];
        dws_pkg::REG_DAMP_A:     coef.damp_a     <= cfg_data;
        dws_pkg::REG_DAMP_B:     coef.damp_b     <= cfg_data;
        dws_pkg::REG_STIFF_A:    coef.stiff_a    <= cfg_data;
        dws_pkg::REG_STIFF_B:    coef.stiff_b    <= cfg_data;
        dws_pkg::REG_DAMP_SIDE:  coef.damp_side  <= cfg_data;
        dws_pkg::REG_STIFF_SIDE: coef.stiff_side <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- rtl/dws_sine_rom.sv -----
// Drive waveform ROM: one period of sine, Q5.18, with a registered read.
// Depends on dws_pkg::sine_from_angle to fill the table at elaboration.
module dws_sine_rom #(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int IDX_W            = $clog2(SINE_TABLE_DEPTH)
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [IDX_W-1:0]         idx,
  output logic signed [22:0]       data
);

  logic signed [22:0] rom [SINE_TABLE_DEPTH];

  for (genvar i = 0; i < SINE_TABLE_DEPTH; i++) begin : g_rom
    localparam logic [63:0] ANG = (64'(i) << 32) / SINE_TABLE_DEPTH;
    assign rom[i] = dws_pkg::sine_from_angle(ANG);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data <= rom[idx];
    end
  end

endmodule

// ----- rtl/dws_pipe.sv -----
// Four-stage update pipeline of the damped wave stencil cell.
// Depends on dws_pkg and on dws_sine_rom for the driven-edge waveform.
module dws_pipe #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dws_pkg::coef_t       coef,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [23:0]   phi_center,
  input  logic signed [23:0]   phi_east,
  input  logic signed [23:0]   phi_west,
  input  logic signed [23:0]   phi_north,
  input  logic signed [23:0]   phi_south,
  input  logic signed [23:0]   phi_inward,
  input  logic signed [23:0]   psi_center,
  input  logic                 in_medium_a,
  input  logic [1:0]           edge_kind,
  input  logic signed [31:0]   drive_phase,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [22:0]   phi_next,
  output logic signed [22:0]   psi_next
);

  localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH);
  localparam int PROD_W = 16 + IDX_W;

  // Stage enables: a stage loads when it is empty or its word moves on.
  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4     = !out_valid || out_ready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  // ---------------- stage 1: operand preparation, Courant squared --------
  dws_pkg::edge_kind_t kind_in;
  logic signed [25:0]  base_c;
  logic signed [26:0]  delta_c;
  logic signed [24:0]  dxy_c;
  logic signed [24:0]  dxi_c;
  logic [15:0]         c_sel;
  logic [23:0]         g_med;
  logic [23:0]         k_med;
  logic [31:0]         mop_a_c;
  logic signed [26:0]  mop_b_c;
  logic [23:0]         k_c;
  logic [23:0]         g_c;
  logic [15:0]         phase16;
  logic [PROD_W-1:0]   idx_prod;

  always_comb begin
    kind_in = dws_pkg::edge_kind_t'(edge_kind);
    base_c  = (26'(phi_center) <<< 1) - 26'(psi_center);
    delta_c = 27'(phi_east) + 27'(phi_west) + 27'(phi_north) + 27'(phi_south)
              - (27'(phi_center) <<< 2);
    dxy_c   = 25'(phi_center) - 25'(psi_center);
    dxi_c   = 25'(phi_center) - 25'(phi_inward);
    c_sel   = in_medium_a ? coef.courant_a : coef.courant_b;
    g_med   = in_medium_a ? coef.damp_a : coef.damp_b;
    k_med   = in_medium_a ? coef.stiff_a : coef.stiff_b;
    case (kind_in)
      dws_pkg::KIND_INTERIOR: begin
        mop_a_c = c_sel * c_sel;
        mop_b_c = delta_c;
        k_c     = k_med;
        g_c     = g_med;
      end
      dws_pkg::KIND_TOPBOT: begin
        mop_a_c = {16'd0, c_sel};
        mop_b_c = 27'(dxi_c);
        k_c     = dws_pkg::TOPBOT_STIFF;
        g_c     = dws_pkg::TOPBOT_DAMP;
      end
      default: begin
        mop_a_c = {16'd0, c_sel};
        mop_b_c = 27'(dxi_c);
        k_c     = coef.stiff_side;
        g_c     = coef.damp_side;
      end
    endcase
    // Negative phases clamp to zero; only the position within a turn counts.
    phase16  = drive_phase[31] ? 16'd0 : drive_phase[15:0];
    idx_prod = PROD_W'(phase16) * PROD_W'(SINE_TABLE_DEPTH);
  end

  dws_pkg::edge_kind_t kind1;
  logic signed [23:0]  x1;
  logic signed [25:0]  base1;
  logic [31:0]         mop_a1;
  logic signed [26:0]  mop_b1;
  logic [23:0]         k1;
  logic [23:0]         g1;
  logic signed [24:0]  dxy1;
  logic [IDX_W-1:0]    idx1;
  logic signed [22:0]  psi1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
    if (rdy1) begin
      kind1  <= kind_in;
      x1     <= phi_center;
      base1  <= base_c;
      mop_a1 <= mop_a_c;
      mop_b1 <= mop_b_c;
      k1     <= k_c;
      g1     <= g_c;
      dxy1   <= dxy_c;
      idx1   <= idx_prod[PROD_W-1:16];
      psi1   <= dws_pkg::sat10(64'(phi_center));
    end
  end

  // ---------------- stage 2: the three products, ROM read ----------------
  dws_pkg::edge_kind_t kind2;
  logic signed [23:0]  x2;
  logic signed [25:0]  base2;
  logic signed [59:0]  m2;
  logic signed [48:0]  kx2;
  logic signed [49:0]  gd2;
  logic signed [22:0]  psi2;
  logic signed [22:0]  sine2;

  dws_sine_rom #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .IDX_W            (IDX_W)
  ) u_rom (
    .clk  (clk),
    .en   (rdy2),
    .idx  (idx1),
    .data (sine2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
    if (rdy2) begin
      kind2 <= kind1;
      x2    <= x1;
      base2 <= base1;
      m2    <= signed'({1'b0, mop_a1}) * mop_b1;
      kx2   <= signed'({1'b0, k1}) * x1;
      gd2   <= signed'({1'b0, g1}) * dxy1;
      psi2  <= psi1;
    end
  end

  // ---------------- stage 3: aligned partial sums ------------------------
  logic signed [63:0] t1_c;
  logic signed [63:0] t2_c;
  logic signed [63:0] kg_c;

  always_comb begin
    kg_c = 64'(kx2) + 64'(gd2);
    if (kind2 == dws_pkg::KIND_INTERIOR) begin
      t1_c = (64'(base2) <<< 32) + 64'(m2);
      t2_c = (kg_c <<< 8) - dws_pkg::RND_INTERIOR;
    end else begin
      t1_c = (64'(x2) <<< 24) - (64'(m2) <<< 8);
      t2_c = kg_c - dws_pkg::RND_EDGE;
    end
  end

  dws_pkg::edge_kind_t kind3;
  logic signed [63:0]  t1_3;
  logic signed [63:0]  t2_3;
  logic signed [22:0]  sine3;
  logic signed [22:0]  psi3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
    if (rdy3) begin
      kind3 <= kind2;
      t1_3  <= t1_c;
      t2_3  <= t2_c;
      sine3 <= sine2;
      psi3  <= psi2;
    end
  end

  // ---------------- stage 4: final sum, rounding shift, saturation -------
  logic signed [63:0] acc_c;
  logic signed [63:0] shifted_c;
  logic signed [22:0] phi_c;

  always_comb begin
    acc_c = t1_3 - t2_3;
    if (kind3 == dws_pkg::KIND_INTERIOR) begin
      shifted_c = acc_c >>> 32;
    end else begin
      shifted_c = acc_c >>> 24;
    end
    if (kind3 == dws_pkg::KIND_DRIVEN) begin
      phi_c = sine3;
    end else begin
      phi_c = dws_pkg::sat10(shifted_c);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy4) begin
      out_valid <= v3;
    end
    if (rdy4) begin
      phi_next <= phi_c;
      psi_next <= psi3;
    end
  end

endmodule

// ----- rtl/dws_checker.sv -----
// Port-level checks for the damped wave stencil cell, bound to its top level.
// Depends only on the top level's ports.
module dws_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [22:0] phi_next,
  input logic signed [22:0] psi_next
);

  // A result that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(phi_next) && $stable(psi_next))
    else $error("result word changed or vanished while stalled");

  // Nothing comes out right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word valid right after reset");

  // An always-ready consumer never throttles the input side.
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled although the output side is ready");

  // Both results stay within plus or minus 10.0.
  a_saturated: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (phi_next <= 23'sd2621440) && (phi_next >= -23'sd2621440)
                  && (psi_next <= 23'sd2621440) && (psi_next >= -23'sd2621440))
    else $error("result word outside the saturation range");

endmodule

bind damped_wave_stencil_cell dws_checker u_dws_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .phi_next  (phi_next),
  .psi_next  (psi_next)
);

// ----- dv/tb_top.sv -----
// Self-checking testbench for damped_wave_stencil_cell: directed cells, then random
// cells under several coefficient settings. Depends on rtl/dws_pkg.sv and the RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD = 10;
  localparam int SINE_DEPTH = 1024;
  // Register stages of the block, the output register included.
  localparam int PIPE_DEPTH = 4;
  localparam int ITEMS_PER_SET = 80;
  localparam int IDLE_PCT = 25;

  // Field extremes in Q6.18, the saturation limit and a few handy values.
  localparam int FMAX = 8388607;
  localparam int FMIN = -8388608;
  localparam int TEN = 2621440;
  localparam int WAVE_ONE = 262144;
  localparam int WAVE_SPAN = 524288;
  localparam int NBR_SPAN = 65536;
  localparam logic signed [31:0] PHASE_MIN = 32'sh80000000;
  localparam logic signed [31:0] PHASE_MAX = 32'sh7FFFFFFF;

  // The top and bottom edges use fixed coefficients in Q0.24.
  localparam longint TOPBOT_DAMP_Q24 = 17;
  localparam longint TOPBOT_STIFF_Q24 = 0;

  // Sine ROM arithmetic, Q30.
  localparam bit [63:0] Q30_ONE = 64'd1073741824;
  localparam bit [63:0] Q30_HALF_PI = 64'd1686629713;
  localparam bit [63:0] TAYLOR_DIV [5] = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

  // Register indexes that fall outside the register file; writes to them are dropped.
  localparam logic [dws_pkg::CFG_IDX_W-1:0] REG_PAST_END = dws_pkg::REG_STIFF_SIDE + 8'd1;
  localparam logic [dws_pkg::CFG_IDX_W-1:0] REG_TOP_INDEX = 8'hFF;

  // Coefficient settings that the random part goes through, one after another.
  typedef enum int {
    SET_RESET   = 0,
    SET_MAX     = 1,
    SET_ZERO    = 2,
    SET_WIDE    = 3,
    SET_TYPICAL = 4
  } coef_set_t;

  // One cell word as it enters the block.
  typedef struct packed {
    dws_pkg::edge_kind_t kind;
    logic               med_a;
    logic signed [23:0] phi_c;
    logic signed [23:0] phi_e;
    logic signed [23:0] phi_w;
    logic signed [23:0] phi_n;
    logic signed [23:0] phi_s;
    logic signed [23:0] phi_in;
    logic signed [23:0] psi_c;
    logic signed [31:0] phase;
  } cell_word_t;

  // One cell update as it leaves the block.
  typedef struct packed {
    logic signed [22:0] phi;
    logic signed [22:0] psi;
  } cell_update_t;

  // A directed row: the word, and the update typed in by hand where it is obvious.
  typedef struct packed {
    cell_word_t   word;
    logic         typed;
    cell_update_t want;
  } stim_row_t;

  // The directed part. Rows with typed set carry an update that can be read straight off
  // the update rules; the others go through the predictor like the random words.
  localparam stim_row_t DIRECTED [25] = '{
    // Interior cells. Flat fields in medium A at reset leave the value unchanged.
    '{'{dws_pkg::KIND_INTERIOR, 1'b1, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0}},
    '{'{dws_pkg::KIND_INTERIOR, 1'b1, 1000, 1000, 1000, 1000, 1000, 1000, 1000, 0},
      1'b1, '{1000, 1000}},
    '{'{dws_pkg::KIND_INTERIOR, 1'b1, FMIN, FMIN, FMIN, FMIN, FMIN, FMIN, FMIN, 0},
      1'b1, '{-TEN, -TEN}},
    '{'{dws_pkg::KIND_INTERIOR, 1'b1, FMAX, FMAX, FMAX, FMAX, FMAX, FMAX, FMAX, 0},
      1'b1, '{TEN, TEN}},
    '{'{dws_pkg::KIND_INTERIOR, 1'b0, 1000, 1000, 1000, 1000, 1000, 1000, 1000, 0},
      1'b0, '{0, 0}},
    '{'{dws_pkg::KIND_INTERIOR, 1'b1, FMAX, FMIN, FMIN, FMIN, FMIN, 0, FMIN, 0},
      1'b0, '{0, 0}},
    '{'{dws_pkg::KIND_INTERIOR, 1'b0, FMIN, FMAX, FMAX, FMAX, FMAX, 0, FMAX, 0},
      1'b0, '{0, 0}},
    '{'{dws_pkg::KIND_INTERIOR, 1'b1, WAVE_ONE, 0, 0, 0, 0, 0, 0, 0}, 1'b0, '{0, 0}},
    // Top and bottom edges have no stiffness, so a flat field stays put.
    '{'{dws_pkg::KIND_TOPBOT, 1'b1, 5000, 5000, 5000, 5000, 5000, 5000, 5000, 0},
      1'b1, '{5000, 5000}},
    '{'{dws_pkg::KIND_TOPBOT, 1'b0, FMAX, 0, 0, 0, 0, FMIN, FMIN, 0}, 1'b0, '{0, 0}},
    '{'{dws_pkg::KIND_TOPBOT, 1'b1, FMIN, 0, 0, 0, 0, FMAX, FMAX, 0}, 1'b0, '{0, 0}},
    // Left and right edges.
    '{'{dws_pkg::KIND_SIDE, 1'b1, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0}},
    '{'{dws_pkg::KIND_SIDE, 1'b0, WAVE_ONE, WAVE_ONE, WAVE_ONE, WAVE_ONE, WAVE_ONE,
        WAVE_ONE, WAVE_ONE, 0}, 1'b0, '{0, 0}},
    '{'{dws_pkg::KIND_SIDE, 1'b1, FMAX, 0, 0, 0, 0, FMIN, FMIN, 0}, 1'b0, '{0, 0}},
    '{'{dws_pkg::KIND_SIDE, 1'b0, FMIN, 0, 0, 0, 0, FMAX, 0, 0}, 1'b0, '{0, 0}},
    // Driven cells: zero phase, negative phases clamped to zero, the half turn, and a
    // phase many turns out whose low 16 bits are zero all give a zero sample.
    '{'{dws_pkg::KIND_DRIVEN, 1'b1, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0}},
    '{'{dws_pkg::KIND_DRIVEN, 1'b1, FMAX, FMIN, FMIN, FMIN, FMIN, FMIN, FMIN, PHASE_MIN},
      1'b1, '{0, TEN}},
    '{'{dws_pkg::KIND_DRIVEN, 1'b0, FMIN, FMAX, FMAX, FMAX, FMAX, FMAX, FMAX, -1},
      1'b1, '{0, -TEN}},
    '{'{dws_pkg::KIND_DRIVEN, 1'b1, 100, 0, 0, 0, 0, 0, 0, 32768}, 1'b1, '{0, 100}},
    '{'{dws_pkg::KIND_DRIVEN, 1'b1, 0, 0, 0, 0, 0, 0, 0, 32'sh7FFF0000}, 1'b1, '{0, 0}},
    '{'{dws_pkg::KIND_DRIVEN, 1'b1, WAVE_ONE, FMAX, FMAX, FMAX, FMAX, FMAX, FMAX, 16384},
      1'b0, '{0, 0}},
    '{'{dws_pkg::KIND_DRIVEN, 1'b0, 0, 0, 0, 0, 0, 0, 0, 49152}, 1'b0, '{0, 0}},
    '{'{dws_pkg::KIND_DRIVEN, 1'b1, 0, 0, 0, 0, 0, 0, 0, PHASE_MAX}, 1'b0, '{0, 0}},
    '{'{dws_pkg::KIND_DRIVEN, 1'b0, 0, 0, 0, 0, 0, 0, 0, 73728}, 1'b0, '{0, 0}},
    // Just below the first table step the index is still zero.
    '{'{dws_pkg::KIND_DRIVEN, 1'b0, -100, 0, 0, 0, 0, 0, 0, 63}, 1'b1, '{0, -100}}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [dws_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [dws_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [23:0] phi_center = '0;
  logic signed [23:0] phi_east = '0;
  logic signed [23:0] phi_west = '0;
  logic signed [23:0] phi_north = '0;
  logic signed [23:0] phi_south = '0;
  logic signed [23:0] phi_inward = '0;
  logic signed [23:0] psi_center = '0;
  logic in_medium_a = 1'b0;
  logic [1:0] edge_kind = '0;
  logic signed [31:0] drive_phase = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [22:0] phi_next;
  logic signed [22:0] psi_next;

  // Our copy of the coefficient registers, indexed by register index. The Courant
  // registers keep only the low 16 bits of a write.
  logic [23:0] coef_shadow [8];
  // Updates predicted for accepted words, oldest first.
  cell_update_t pending_updates [$];
  int error_count = 0;
  // While set, neither side of the block idles.
  bit calm = 1'b0;

  damped_wave_stencil_cell #(
    .SINE_TABLE_DEPTH(SINE_DEPTH)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .phi_center  (phi_center),
    .phi_east    (phi_east),
    .phi_west    (phi_west),
    .phi_north   (phi_north),
    .phi_south   (phi_south),
    .phi_inward  (phi_inward),
    .psi_center  (psi_center),
    .in_medium_a (in_medium_a),
    .edge_kind   (edge_kind),
    .drive_phase (drive_phase),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .phi_next    (phi_next),
    .psi_next    (psi_next)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Clamp to plus or minus 10.0 and narrow to the 23-bit output format.
  function automatic logic signed [22:0] clamp_ten(input longint v);
    if (v > TEN) begin
      return 23'(TEN);
    end else if (v < -TEN) begin
      return 23'(-TEN);
    end
    return 23'(v);
  endfunction

  // Leapfrog update of one cell under the coefficients currently in coef_shadow.
  // Interior and edge sums are exact in 64 bits, then rounded half up; a floor shift
  // after adding half an output step does exactly that for negative sums too.
  function automatic cell_update_t leapfrog_update(input cell_word_t c);
    longint x;
    longint y;
    longint inw;
    longint lap;
    longint crt;
    longint damp;
    longint stiff;
    longint acc;
    longint val;
    bit [63:0] p;
    bit [63:0] idx;
    bit [63:0] ang;
    bit [63:0] r;
    bit [63:0] xs;
    bit [63:0] x2;
    bit [63:0] t;
    bit [63:0] s;
    bit [63:0] v;
    bit [1:0] quad;
    cell_update_t upd;
    x = c.phi_c;
    y = c.psi_c;
    inw = c.phi_in;
    crt = c.med_a ? coef_shadow[dws_pkg::REG_COURANT_A]
                  : coef_shadow[dws_pkg::REG_COURANT_B];
    damp = c.med_a ? coef_shadow[dws_pkg::REG_DAMP_A] : coef_shadow[dws_pkg::REG_DAMP_B];
    stiff = c.med_a ? coef_shadow[dws_pkg::REG_STIFF_A]
                    : coef_shadow[dws_pkg::REG_STIFF_B];
    case (c.kind)
      dws_pkg::KIND_INTERIOR: begin
        // Terms aligned at 50 fraction bits: Courant squared is Q0.32, the
        // Q0.24 coefficients are lifted by 8 bits.
        lap = longint'(c.phi_e) + c.phi_w + c.phi_n + c.phi_s - 4 * x;
        acc = ((2 * x - y) <<< 32) + crt * crt * lap - stiff * x * 256
              - damp * (x - y) * 256;
        val = (acc + (longint'(1) <<< 31)) >>> 32;
      end
      dws_pkg::KIND_TOPBOT, dws_pkg::KIND_SIDE: begin
        // One-sided rule at 42 fraction bits.
        if (c.kind == dws_pkg::KIND_TOPBOT) begin
          stiff = TOPBOT_STIFF_Q24;
          damp = TOPBOT_DAMP_Q24;
        end else begin
          stiff = coef_shadow[dws_pkg::REG_STIFF_SIDE];
          damp = coef_shadow[dws_pkg::REG_DAMP_SIDE];
        end
        acc = (x <<< 24) - crt * (x - inw) * 256 - stiff * x - damp * (x - y);
        val = (acc + (longint'(1) <<< 23)) >>> 24;
      end
      default: begin
        // Negative phases clamp to zero; only the position within one turn counts.
        p = (c.phase < 0) ? 64'd0 : 64'(c.phase);
        idx = ((p & 64'hFFFF) * SINE_DEPTH) >> 16;
        ang = (idx << 32) / SINE_DEPTH;
        quad = ang[31:30];
        r = {34'd0, ang[29:0]};
        if (quad[0]) begin
          r = Q30_ONE - r;
        end
        xs = (r * Q30_HALF_PI) >> 30;
        x2 = (xs * xs) >> 30;
        t = Q30_ONE;
        for (int k = 0; k < 5; k++) begin
          t = Q30_ONE - ((x2 * t) >> 30) / TAYLOR_DIV[k];
        end
        s = (xs * t) >> 30;
        v = (s + 64'd2048) >> 12;
        val = quad[1] ? -longint'(v) : longint'(v);
      end
    endcase
    upd.phi = clamp_ten(val);
    upd.psi = clamp_ten(x);
    return upd;
  endfunction

  // A field value: half the time within plus or minus 2.0 as in a real wave, otherwise the
  // full 24-bit range or one of its ends.
  function automatic logic signed [23:0] pick_field();
    case ($urandom_range(9))
      0: return 24'(FMAX);
      1: return 24'(FMIN);
      2, 3, 4: return 24'($urandom);
      default: return 24'($signed($urandom_range(2 * WAVE_SPAN)) - WAVE_SPAN);
    endcase
  endfunction

  // A neighbor field: usually close to the cell's own value, otherwise unrelated.
  function automatic logic signed [23:0] near_field(input logic signed [23:0] base);
    if ($urandom_range(9) < 7) begin
      return base + 24'($signed($urandom_range(2 * NBR_SPAN)) - NBR_SPAN);
    end
    return pick_field();
  endfunction

  // Present one word and hold it until the block takes it. Called at a falling edge and
  // returns at one, with in_valid left high so that back-to-back words never drop it.
  // A typed update replaces the predicted one.
  task automatic send_cell(input cell_word_t c, input logic typed,
                           input cell_update_t want);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    phi_center <= c.phi_c;
    phi_east <= c.phi_e;
    phi_west <= c.phi_w;
    phi_north <= c.phi_n;
    phi_south <= c.phi_s;
    phi_inward <= c.phi_in;
    psi_center <= c.psi_c;
    in_medium_a <= c.med_a;
    edge_kind <= c.kind;
    drive_phase <= c.phase;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    pending_updates.push_back(typed ? want : leapfrog_update(c));
    @(negedge clk);
  endtask

  // Write one register, keeping cfg_valid high for a following write. Indexes past the
  // register file are accepted by the block and change nothing.
  task automatic write_reg(input logic [dws_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dws_pkg::CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    if (idx == dws_pkg::REG_COURANT_A || idx == dws_pkg::REG_COURANT_B) begin
      coef_shadow[idx] = {8'd0, data[15:0]};
    end else if (idx <= dws_pkg::REG_STIFF_SIDE) begin
      coef_shadow[idx] = data;
    end
    @(negedge clk);
  endtask

  // Stop sending and wait until every predicted update has come out and nothing is left
  // in flight in the pipeline.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (pending_updates.size() != 0) begin
      @(negedge clk);
    end
    repeat (PIPE_DEPTH + 2) @(negedge clk);
  endtask

  // The result side stalls about a quarter of the time, except while calm is set.
  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Compare every accepted result with the oldest predicted update.
  always @(posedge clk) begin
    cell_update_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_updates.size() == 0) begin
        $error("result with no word pending: phi_next %0d, psi_next %0d", phi_next, psi_next);
        error_count++;
      end else begin
        want = pending_updates.pop_front();
        if (phi_next !== want.phi) begin
          $error("phi_next: expected %0d, got %0d", want.phi, phi_next);
          error_count++;
        end
        if (psi_next !== want.psi) begin
          $error("psi_next: expected %0d, got %0d", want.psi, psi_next);
          error_count++;
        end
      end
    end
  end

  initial begin
    cell_word_t rc;
    logic [dws_pkg::CFG_DATA_W-1:0] val;
    coef_shadow[dws_pkg::REG_COURANT_A] = 24'd1311;
    coef_shadow[dws_pkg::REG_COURANT_B] = 24'd655;
    coef_shadow[dws_pkg::REG_DAMP_A] = 24'd34;
    coef_shadow[dws_pkg::REG_DAMP_B] = 24'd4194;
    coef_shadow[dws_pkg::REG_STIFF_A] = 24'd0;
    coef_shadow[dws_pkg::REG_STIFF_B] = 24'd17;
    coef_shadow[dws_pkg::REG_DAMP_SIDE] = 24'd1678;
    coef_shadow[dws_pkg::REG_STIFF_SIDE] = 24'd8389;

    // Reset is held from the start and released on a falling edge.
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed cells under the reset coefficients.
    foreach (DIRECTED[i]) begin
      send_cell(DIRECTED[i].word, DIRECTED[i].typed, DIRECTED[i].want);
    end

    // Random cells, one batch per coefficient setting. The first batch keeps the reset
    // coefficients and runs with no idling on either side. Before every other batch the
    // sender waits until all results are back, so the registers change only while the
    // block is empty.
    for (int set = SET_RESET; set <= SET_TYPICAL; set++) begin
      calm = (set == SET_RESET);
      if (set != SET_RESET) begin
        drain_pipeline();
        for (int r = dws_pkg::REG_COURANT_A; r <= dws_pkg::REG_STIFF_SIDE; r++) begin
          case (set)
            SET_MAX: val = '1;
            SET_ZERO: val = '0;
            SET_WIDE: val = dws_pkg::CFG_DATA_W'($urandom);
            default: begin
              // Values near the reset ones, with junk above bit 15 of a Courant write.
              val = dws_pkg::CFG_DATA_W'($urandom_range(16384));
              if (r == dws_pkg::REG_COURANT_A || r == dws_pkg::REG_COURANT_B) begin
                val[23:16] = 8'($urandom);
              end
            end
          endcase
          write_reg(dws_pkg::CFG_IDX_W'(r), val);
          if (set == SET_TYPICAL && r == dws_pkg::REG_DAMP_B) begin
            write_reg(REG_PAST_END, '1);
            write_reg(REG_TOP_INDEX, dws_pkg::CFG_DATA_W'($urandom));
          end
        end
        cfg_valid <= 1'b0;
      end
      repeat (ITEMS_PER_SET) begin
        rc.kind = dws_pkg::edge_kind_t'($urandom_range(3));
        rc.med_a = 1'($urandom_range(1));
        rc.phi_c = pick_field();
        rc.phi_e = near_field(rc.phi_c);
        rc.phi_w = near_field(rc.phi_c);
        rc.phi_n = near_field(rc.phi_c);
        rc.phi_s = near_field(rc.phi_c);
        rc.phi_in = near_field(rc.phi_c);
        rc.psi_c = near_field(rc.phi_c);
        case ($urandom_range(3))
          0: rc.phase = 32'($urandom);
          1: rc.phase = 32'($urandom_range(65535));
          2: rc.phase = -32'sd1 - 32'($urandom_range(65535));
          default: rc.phase = {16'($urandom_range(1, 32767)), 16'($urandom)};
        endcase
        send_cell(rc, 1'b0, '0);
      end
    end

    calm = 1'b0;
    drain_pipeline();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(2ms);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
